// ===== design/assert_macros.svh =====
// Assertion helpers used by negacyclic_poly_mult_mod_q.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/npmq_pkg.sv =====
package npmq_pkg;

	// Default ring length and fixed field widths
	localparam int POLY_DEGREE_DEF = 256;
	localparam int COEFF_W = 12;
	localparam int INDEX_W = 8;
	localparam int KIND_W = 2;

	// Input beat kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	typedef logic [COEFF_W-1:0] coeff_t;

	localparam coeff_t MODQ = 12'd3329;

	// Per-cycle commands broadcast to every cell of the ring
	typedef struct packed {
		logic copy_w;     // load working operand from stored operand, clear partial product
		logic shift_w;    // rotate working operand one cell along the ring
		logic mul_step;   // one MSB-first step of the bit-serial modular multiply
		logic a_bit;      // multiplier bit for this step
		logic add_acc;    // fold partial product into the accumulator
		logic clear_acc;  // zero the accumulator
	} cell_ctrl_t;

	// Fold a 12-bit value once into 0..q-1
	function automatic coeff_t mod_reduce(input coeff_t x);
		return (x >= MODQ) ? coeff_t'(x - MODQ) : x;
	endfunction

	// Modular add of two values already in 0..q-1
	function automatic coeff_t mod_add(input coeff_t x, input coeff_t y);
		logic [COEFF_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, MODQ}) begin
			s = s - {1'b0, MODQ};
		end
		return s[COEFF_W-1:0];
	endfunction

	// Modular negation of a value in 0..q-1
	function automatic coeff_t mod_neg(input coeff_t x);
		return (x == '0) ? '0 : coeff_t'(MODQ - x);
	endfunction

endpackage

// ===== design/npmq_cell.sv =====
module npmq_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  npmq_pkg::cell_ctrl_t ctrl,
	input  logic                 load_en,
	input  npmq_pkg::coeff_t     load_value,
	input  npmq_pkg::coeff_t     w_in,
	output npmq_pkg::coeff_t     w_out,
	output npmq_pkg::coeff_t     acc
);

	npmq_pkg::coeff_t b_q;
	npmq_pkg::coeff_t w_q;
	npmq_pkg::coeff_t m_q;
	npmq_pkg::coeff_t acc_q;
	npmq_pkg::coeff_t dbl;

	// Partial product doubled modulo q for the next multiply step
	assign dbl = npmq_pkg::mod_add(m_q, m_q);

	// Hold operand coefficient, rotate working copy, run bit-serial multiply
	always_ff @(posedge clk) begin
		if (load_en) begin
			b_q <= load_value;
		end
		if (ctrl.copy_w) begin
			w_q <= b_q;
		end else if (ctrl.shift_w) begin
			w_q <= w_in;
		end
		if (ctrl.copy_w) begin
			m_q <= '0;
		end else if (ctrl.mul_step) begin
			m_q <= npmq_pkg::mod_add(dbl, ctrl.a_bit ? w_q : '0);
		end
	end

	// Accumulate product coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear_acc) begin
			acc_q <= '0;
		end else if (ctrl.add_acc) begin
			acc_q <= npmq_pkg::mod_add(acc_q, m_q);
		end
	end

	assign w_out = w_q;
	assign acc = acc_q;

endmodule

// ===== design/negacyclic_poly_mult_mod_q.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: kind; tdata: coeff_index, coeff_value
// m_*      out  m_tvalid/m_tready  tdata: result_index, result_value
//
// Load, read and clear beats start no sequence that holds the input.
// An accumulate beat with index i holds the input until all of its steps are done:
// i single-cell rotations of the operand ring, 12 bit-serial multiply steps, one add.
// Reset zeroes every accumulator at once; the operand store is not reset.
// A read result sits in an output register; a new beat is taken while it waits
// only if m_tready is high in that cycle.
`include "assert_macros.svh"

module negacyclic_poly_mult_mod_q #(
	parameter int POLY_DEGREE = npmq_pkg::POLY_DEGREE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] coeff_index, [19:8] coeff_value, [23:20] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [7:0] result_index, [19:8] result_value, [23:20] zero
);

	localparam int IDX_W = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;
	localparam int BIT_W = $clog2(npmq_pkg::COEFF_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_ADD  = 2'd3;

	logic [1:0]                         kind;
	logic [npmq_pkg::INDEX_W-1:0]       idx;
	npmq_pkg::coeff_t                   val;
	logic                               in_range;
	logic                               accept;
	logic [IDX_W-1:0]                   rd_sel;

	logic [1:0]                         state_q;
	logic [npmq_pkg::INDEX_W-1:0]       rot_q;
	logic [BIT_W-1:0]                   bit_q;
	npmq_pkg::coeff_t                   a_q;

	logic                               out_valid_q;
	logic [npmq_pkg::INDEX_W-1:0]       out_index_q;
	npmq_pkg::coeff_t                   out_value_q;

	npmq_pkg::cell_ctrl_t               ctrl;
	npmq_pkg::coeff_t                   w_out [POLY_DEGREE];
	npmq_pkg::coeff_t                   w_in  [POLY_DEGREE];
	npmq_pkg::coeff_t                   acc   [POLY_DEGREE];
	logic [POLY_DEGREE-1:0]             load_en;

	// Unpack the input beat
	assign kind = s_tuser;
	assign idx = s_tdata[7:0];
	assign val = npmq_pkg::mod_reduce(s_tdata[19:8]);
	assign in_range = 32'(idx) < 32'(POLY_DEGREE);
	assign rd_sel = IDX_W'(idx);

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid || m_tready);
	assign accept = s_tvalid && s_tready;

	// Sequence one accumulate: copy, rotate, multiply, add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rot_q <= '0;
			bit_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && kind == npmq_pkg::KIND_ACC && in_range) begin
						rot_q <= idx;
						bit_q <= BIT_W'(npmq_pkg::COEFF_W - 1);
						state_q <= (idx == '0) ? ST_MUL : ST_ROT;
					end
				end
				ST_ROT: begin
					rot_q <= rot_q - 1'b1;
					if (rot_q == npmq_pkg::INDEX_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the multiplier coefficient
	always_ff @(posedge clk) begin
		if (accept && kind == npmq_pkg::KIND_ACC) begin
			a_q <= val;
		end
	end

	// Drive the cell commands
	always_comb begin
		ctrl = '0;
		ctrl.copy_w = accept && kind == npmq_pkg::KIND_ACC && in_range;
		ctrl.clear_acc = accept && kind == npmq_pkg::KIND_CLEAR;
		ctrl.shift_w = state_q == ST_ROT;
		ctrl.mul_step = state_q == ST_MUL;
		ctrl.a_bit = a_q[bit_q];
		ctrl.add_acc = state_q == ST_ADD;
	end

	// Ring of cells; the wrap into cell zero negates the coefficient
	for (genvar k = 0; k < POLY_DEGREE; k++) begin : g_cell
		if (k == 0) begin : g_wrap
			assign w_in[k] = npmq_pkg::mod_neg(w_out[POLY_DEGREE-1]);
		end else begin : g_link
			assign w_in[k] = w_out[k-1];
		end

		assign load_en[k] = accept && kind == npmq_pkg::KIND_LOAD && in_range
			&& rd_sel == IDX_W'(k);

		npmq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.load_en    (load_en[k]),
			.load_value (val),
			.w_in       (w_in[k]),
			.w_out      (w_out[k]),
			.acc        (acc[k])
		);
	end

	// Output register for read results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && kind == npmq_pkg::KIND_READ) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == npmq_pkg::KIND_READ) begin
			out_index_q <= idx;
			out_value_q <= in_range ? acc[rd_sel] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0000, out_value_q, out_index_q};

	// Checks
	`ASSERT_IMPLIES(a_busy_blocks_input, clk, arst_n, state_q != ST_IDLE, !s_tready,
		"input taken while an accumulate runs")
	`ASSERT_NEXT(a_read_gives_result, clk, arst_n, accept && kind == npmq_pkg::KIND_READ,
		m_tvalid, "read beat produced no result")
	`ASSERT_NEXT(a_rotate_starts, clk, arst_n,
		accept && kind == npmq_pkg::KIND_ACC && in_range && idx != '0,
		state_q == ST_ROT && rot_q == $past(idx), "accumulate did not start rotation")
	`ASSERT_NEXT(a_mul_ends_in_add, clk, arst_n, state_q == ST_MUL && bit_q == '0,
		state_q == ST_ADD, "multiply did not end in the add step")

endmodule
